// ===== hdl/gfd_pkg.sv =====
// Shared types and constants of the grid finite-difference block.
package gfd_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int MAG_W     = 33;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int CCOUNT_W  = 11;
  localparam int INV_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_COL_STEP = 3'd4;

  // Descriptor of one result as it travels down a scaling lane.
  typedef struct packed {
    logic                 v;
    logic                 k17;
    logic                 neg;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t                tag;
    logic [SAMPLE_W-1:0] slope;
  } result_t;

endpackage

// ===== hdl/gfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gfd_front.sv =====
// Configuration registers, grid position tracking, line buffer and difference stage.
module gfd_front #(
  parameter int MAX_COLS = 1024,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [gfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfd_pkg::INV_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic [gfd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          pipe_en,
  output gfd_pkg::tag_t                 tag_a,
  output logic [gfd_pkg::MAG_W-1:0]     mag_a,
  output gfd_pkg::tag_t                 tag_b,
  output logic [gfd_pkg::MAG_W-1:0]     mag_b,
  output logic [gfd_pkg::INV_W-1:0]     inv
);

  localparam int CW = (COL_W + 1 > gfd_pkg::CCOUNT_W) ? COL_W + 1 : gfd_pkg::CCOUNT_W;
  localparam int SW = gfd_pkg::SAMPLE_W;
  localparam int RW = gfd_pkg::ROW_W;

  // Configuration registers.
  logic                         dir_r;
  logic [RW-1:0]                row_count_r;
  logic [gfd_pkg::CCOUNT_W-1:0] col_count_r;
  logic [gfd_pkg::INV_W-1:0]    inv_row_r;
  logic [gfd_pkg::INV_W-1:0]    inv_col_r;
  logic                         restart;

  // Position and horizontal history.
  logic [RW-1:0]    row_r;
  logic [COL_W-1:0] col_r;
  logic [SW-1:0]    prev_r;
  logic [SW-1:0]    pp_r;

  // Stage holding the accepted request while the line buffer is read.
  logic             sa_v_r;
  logic [COL_W-1:0] sa_idx_r;
  logic [SW-1:0]    sa_s_r;
  logic [SW-1:0]    sa_near_r;
  logic [SW-1:0]    sa_far_r;
  gfd_pkg::tag_t    sa_t1_r;
  gfd_pkg::tag_t    sa_t2_r;

  logic             accept;
  logic [RW-1:0]    rows_eff;
  logic [CW-1:0]    cc_ext;
  logic [CW-1:0]    cols_eff;
  logic             last_row;
  logic             last_col;
  logic             pos_is_one;
  logic             pos_nonzero;
  logic             last_along;
  logic             last_across;
  gfd_pkg::tag_t    t1_nxt;
  gfd_pkg::tag_t    t2_nxt;

  logic [2*SW-1:0]  rdata;
  logic [SW-1:0]    above;
  logic [SW-1:0]    two_above;
  logic [SW-1:0]    near;
  logic [SW-1:0]    far;
  logic [SW-1:0]    opnd1;
  logic [gfd_pkg::MAG_W-1:0] s_ext;
  logic [gfd_pkg::MAG_W-1:0] o1_ext;
  logic [gfd_pkg::MAG_W-1:0] o2_ext;
  logic [gfd_pkg::MAG_W-1:0] d1;
  logic [gfd_pkg::MAG_W-1:0] d2;

  assign accept = in_valid && pipe_en;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        gfd_pkg::CFG_DIRECTION,
        gfd_pkg::CFG_ROW_COUNT,
        gfd_pkg::CFG_COL_COUNT,
        gfd_pkg::CFG_INV_ROW_STEP,
        gfd_pkg::CFG_INV_COL_STEP: restart = 1'b1;
        default:                   restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b1;
      row_count_r <= RW'(2);
      col_count_r <= gfd_pkg::CCOUNT_W'(2);
      inv_row_r   <= gfd_pkg::INV_W'(65536);
      inv_col_r   <= gfd_pkg::INV_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        gfd_pkg::CFG_DIRECTION:    dir_r       <= cfg_data[0];
        gfd_pkg::CFG_ROW_COUNT:    row_count_r <= cfg_data[RW-1:0];
        gfd_pkg::CFG_COL_COUNT:    col_count_r <= cfg_data[gfd_pkg::CCOUNT_W-1:0];
        gfd_pkg::CFG_INV_ROW_STEP: inv_row_r   <= cfg_data;
        gfd_pkg::CFG_INV_COL_STEP: inv_col_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective grid size, clamped to what the line buffer supports.
  always_comb begin
    rows_eff = (row_count_r < RW'(2)) ? RW'(2) : row_count_r;
    cc_ext   = CW'(col_count_r);
    if (cc_ext < CW'(2)) begin
      cols_eff = CW'(2);
    end else if (cc_ext > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cc_ext;
    end
    last_row    = row_r >= rows_eff - RW'(1);
    last_col    = CW'(col_r) >= cols_eff - CW'(1);
    pos_is_one  = dir_r ? (col_r == COL_W'(1)) : (row_r == RW'(1));
    pos_nonzero = dir_r ? (col_r != '0) : (row_r != '0);
    last_along  = dir_r ? last_col : last_row;
    last_across = dir_r ? last_row : last_col;

    // The earlier point: one-sided at the first position, central otherwise.
    t1_nxt.v    = accept && pos_nonzero;
    t1_nxt.k17  = !pos_is_one;
    t1_nxt.neg  = 1'b0;
    t1_nxt.last = 1'b0;
    t1_nxt.row  = dir_r ? row_r : row_r - RW'(1);
    t1_nxt.col  = dir_r ? gfd_pkg::OUT_COL_W'(col_r - COL_W'(1))
                        : gfd_pkg::OUT_COL_W'(col_r);

    // The current point, one-sided, only at the end of its line or column.
    t2_nxt.v    = accept && pos_nonzero && last_along;
    t2_nxt.k17  = 1'b0;
    t2_nxt.neg  = 1'b0;
    t2_nxt.last = last_across;
    t2_nxt.row  = row_r;
    t2_nxt.col  = gfd_pkg::OUT_COL_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      prev_r <= '0;
      pp_r   <= '0;
    end else if (restart) begin
      row_r  <= '0;
      col_r  <= '0;
      prev_r <= '0;
      pp_r   <= '0;
    end else if (accept) begin
      pp_r   <= prev_r;
      prev_r <= in_sample;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r    <= 1'b0;
      sa_t1_r.v <= 1'b0;
      sa_t2_r.v <= 1'b0;
    end else if (pipe_en) begin
      sa_v_r    <= accept;
      sa_t1_r   <= t1_nxt;
      sa_t2_r   <= t2_nxt;
      sa_idx_r  <= col_r;
      sa_s_r    <= in_sample;
      sa_near_r <= prev_r;
      sa_far_r  <= pp_r;
    end
  end

  // Each entry holds the two lines above; a column is revisited no sooner than
  // two requests later, after its write-back has landed, so no forwarding is needed.
  gfd_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (pipe_en && sa_v_r),
    .waddr (sa_idx_r),
    .wdata ({sa_s_r, above}),
    .re    (accept),
    .raddr (col_r),
    .rdata (rdata)
  );

  always_comb begin
    above     = rdata[2*SW-1:SW];
    two_above = rdata[SW-1:0];
    near      = dir_r ? sa_near_r : above;
    far       = dir_r ? sa_far_r : two_above;
    opnd1     = sa_t1_r.k17 ? far : near;
    s_ext     = {sa_s_r[SW-1], sa_s_r};
    o1_ext    = {opnd1[SW-1], opnd1};
    o2_ext    = {near[SW-1], near};
    d1        = s_ext - o1_ext;
    d2        = s_ext - o2_ext;

    tag_a     = sa_t1_r;
    tag_a.neg = d1[gfd_pkg::MAG_W-1];
    mag_a     = d1[gfd_pkg::MAG_W-1] ? o1_ext - s_ext : d1;
    tag_b     = sa_t2_r;
    tag_b.neg = d2[gfd_pkg::MAG_W-1];
    mag_b     = d2[gfd_pkg::MAG_W-1] ? o2_ext - s_ext : d2;
  end

  assign inv = dir_r ? inv_col_r : inv_row_r;

endmodule

// ===== hdl/gfd_scale.sv =====
// Scaling lane: magnitude times inverse step, rounding and saturation.
module gfd_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  gfd_pkg::tag_t             tag_i,
  input  logic [gfd_pkg::MAG_W-1:0] mag_i,
  input  logic [gfd_pkg::INV_W-1:0] inv_i,
  output gfd_pkg::result_t          res_o
);

  localparam int MW = gfd_pkg::MAG_W;
  localparam int PW = MW + 16;
  localparam int FW = MW + 32;

  gfd_pkg::tag_t    tag1_r;
  gfd_pkg::tag_t    tag2_r;
  gfd_pkg::tag_t    tag3_r;
  gfd_pkg::result_t res_r;
  logic [MW-1:0]    mag_r;
  logic [PW-1:0]    pl_r;
  logic [PW-1:0]    ph_r;
  logic [FW-1:0]    p_r;

  logic [PW-1:0]    pl_nxt;
  logic [PW-1:0]    ph_nxt;
  logic [FW-1:0]    rnd;
  logic [FW-1:0]    p_nxt;
  logic [PW-1:0]    q;
  logic [gfd_pkg::SAMPLE_W-1:0] slope_nxt;

  // The product is split into two 33 x 16 partial products.
  always_comb begin
    pl_nxt = {16'b0, mag_r} * {{MW{1'b0}}, inv_i[15:0]};
    ph_nxt = {16'b0, mag_r} * {{MW{1'b0}}, inv_i[31:16]};
    rnd    = tag2_r.k17 ? FW'(65536) : FW'(32768);
    p_nxt  = {16'b0, pl_r} + {ph_r, 16'b0} + rnd;
    q      = tag3_r.k17 ? {1'b0, p_r[FW-1:17]} : p_r[FW-1:16];
    if (!tag3_r.neg) begin
      slope_nxt = (q > PW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      slope_nxt = (q > PW'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.v    <= 1'b0;
      tag2_r.v    <= 1'b0;
      tag3_r.v    <= 1'b0;
      res_r.tag.v <= 1'b0;
    end else if (en) begin
      tag1_r      <= tag_i;
      mag_r       <= mag_i;
      tag2_r      <= tag1_r;
      pl_r        <= pl_nxt;
      ph_r        <= ph_nxt;
      tag3_r      <= tag2_r;
      p_r         <= p_nxt;
      res_r.tag   <= tag3_r;
      res_r.slope <= slope_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== hdl/gfd_out.sv =====
// Output register pair that hands out up to two results per request in order.
module gfd_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gfd_pkg::result_t             res_a,
  input  gfd_pkg::result_t             res_b,
  input  logic                         out_stall,
  output logic                         pipe_en,
  output logic                         out_valid,
  output logic [gfd_pkg::SAMPLE_W-1:0] out_slope,
  output logic [gfd_pkg::ROW_W-1:0]    out_row,
  output logic [gfd_pkg::OUT_COL_W-1:0] out_col,
  output logic                         out_last_of_grid
);

  gfd_pkg::result_t a_r;
  gfd_pkg::result_t b_r;
  gfd_pkg::result_t head;
  logic             take;

  always_comb begin
    out_valid = a_r.tag.v || b_r.tag.v;
    head      = a_r.tag.v ? a_r : b_r;
    take      = out_valid && !out_stall;
    // The pipeline moves only when the pair will be empty after this cycle.
    pipe_en   = !out_valid || (take && !(a_r.tag.v && b_r.tag.v));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.tag.v <= 1'b0;
      b_r.tag.v <= 1'b0;
    end else if (pipe_en) begin
      a_r <= res_a;
      b_r <= res_b;
    end else if (take) begin
      if (a_r.tag.v) begin
        a_r.tag.v <= 1'b0;
      end else begin
        b_r.tag.v <= 1'b0;
      end
    end
  end

  assign out_slope        = head.slope;
  assign out_row          = head.tag.row;
  assign out_col          = head.tag.col;
  assign out_last_of_grid = head.tag.last;

endmodule

// ===== hdl/grid_finite_difference.sv =====
// Streaming finite-difference derivative of a grid given in raster order.
// Samples are signed Q16.16 and are taken one per clock cycle unless stalled.
// Each sample is followed through a six-stage pipeline (line buffer read,
// difference and magnitude, split multiply, rounding add, saturation, output
// pair) and its results appear in order, tagged with row and column. A sample
// that completes two points (at the end of a line when differentiating along
// rows, or on the last row when differentiating down columns) stalls the input
// while both of its results sit in the output pair. Column mode keeps the two
// previous lines in a single MAX_COLS-deep RAM, read when a sample is taken
// and written back on the next pipeline advance. Any register write restarts
// the grid at row 0, column 0; write configuration only while the block is
// empty. A grid needs at least two rows and two columns.
module grid_finite_difference #(
  parameter int MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfd_pkg::INV_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gfd_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gfd_pkg::SAMPLE_W-1:0]  out_slope,
  output logic [gfd_pkg::ROW_W-1:0]     out_row,
  output logic [gfd_pkg::OUT_COL_W-1:0] out_col,
  output logic                          out_last_of_grid
);

  logic                      pipe_en;
  gfd_pkg::tag_t             tag_a;
  gfd_pkg::tag_t             tag_b;
  logic [gfd_pkg::MAG_W-1:0] mag_a;
  logic [gfd_pkg::MAG_W-1:0] mag_b;
  logic [gfd_pkg::INV_W-1:0] inv;
  gfd_pkg::result_t          res_a;
  gfd_pkg::result_t          res_b;

  assign cfg_ready = 1'b1;
  assign in_stall  = !pipe_en;

  gfd_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .pipe_en   (pipe_en),
    .tag_a     (tag_a),
    .mag_a     (mag_a),
    .tag_b     (tag_b),
    .mag_b     (mag_b),
    .inv       (inv)
  );

  gfd_scale u_scale_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .tag_i (tag_a),
    .mag_i (mag_a),
    .inv_i (inv),
    .res_o (res_a)
  );

  gfd_scale u_scale_b (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .tag_i (tag_b),
    .mag_i (mag_b),
    .inv_i (inv),
    .res_o (res_b)
  );

  gfd_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_a            (res_a),
    .res_b            (res_b),
    .out_stall        (out_stall),
    .pipe_en          (pipe_en),
    .out_valid        (out_valid),
    .out_slope        (out_slope),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_grid (out_last_of_grid)
  );

endmodule
